FILE: design/cfba_pkg.sv
// Shared types and constants for the chained free-block allocator.
// Has no dependencies; the allocator top level imports it.
package cfba_pkg;

  localparam int BLK_W  = 10;
  localparam int STAT_W = 2;

  localparam int DEF_CACHE_SLOTS = 16;
  localparam int DEF_BLOCK_COUNT = 1024;

  localparam logic KIND_FREE  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_ALLOC   = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_FREED   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_CHK,
    ST_MOD,
    ST_MUL,
    ST_SPILL,
    ST_REFILL,
    ST_DONE
  } state_t;

endpackage

FILE: design/chained_free_block_allocator.sv
// Chained free-block allocator: cache of free block numbers spilled to and
// refilled from chain records in an on-chip memory. Depends on cfba_pkg.
//
//  channel | dir | tdata                        | tuser
//  in_     | in  | [9:0] block_number           | [0] kind (0 free, 1 allocate)
//  out_    | out | [9:0] granted_block          | [1:0] status
//
// A plain push writes the cache slot; a plain pop reads the top slot and then
// checks it. A spill adds the two-step record-number reduction (reciprocal
// multiply, then subtract), the base multiply and the record write, a refill
// the same reduction and base multiply and the record read; the single
// memory port moves one record word per cycle. One request is in flight at a
// time; in_tready is low until its result is loaded into the output register.
// Reset is synchronous; the chain memory is not cleared.
module chained_free_block_allocator
  import cfba_pkg::*;
#(
  parameter int CACHE_SLOTS = DEF_CACHE_SLOTS,
  parameter int BLOCK_COUNT = DEF_BLOCK_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] block_number
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] granted_block
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int REC_WORDS = CACHE_SLOTS + 1;
  localparam int REC_COUNT = (BLOCK_COUNT < (1 << BLK_W)) ? BLOCK_COUNT : (1 << BLK_W);
  localparam int CHAIN_DEPTH = REC_COUNT * REC_WORDS;
  localparam int ADDR_W = $clog2(CHAIN_DEPTH);
  localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);
  localparam int CIDX_W = $clog2(CACHE_SLOTS);
  localparam int OFF_W  = $clog2(CACHE_SLOTS + 2);
  // Reciprocal of the record count, exact for every BLK_W-bit block number
  localparam int MOD_SH = 2 * BLK_W;
  localparam int MOD_M  = ((1 << MOD_SH) + REC_COUNT - 1) / REC_COUNT;
  localparam int MOD_MW = $clog2(MOD_M + 1);
  localparam int PROD_W = BLK_W + MOD_MW;

  logic [BLK_W-1:0] cache_mem [CACHE_SLOTS];
  logic [BLK_W-1:0] chain_mem [CHAIN_DEPTH];

  state_t             state_r, state_nxt;
  logic               kind_r, kind_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BLK_W-1:0]   rem_r, rem_nxt;
  logic               mod_ph_r, mod_ph_nxt;
  logic [BLK_W-1:0]   quo_r, quo_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [OFF_W-1:0]   idx_r, idx_nxt;
  logic [BLK_W-1:0]   got_r, got_nxt;
  status_t            status_r, status_nxt;
  logic               slot0_vld_r, slot0_vld_nxt;
  logic               rd_zero_r;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [BLK_W-1:0]   out_block_r, out_block_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               cache_we, cache_re;
  logic [CIDX_W-1:0]  cache_waddr, cache_raddr;
  logic [BLK_W-1:0]   cache_wdata, cache_rd_q, cache_rd;
  logic               chain_we, chain_re;
  logic [ADDR_W-1:0]  chain_addr;
  logic [BLK_W-1:0]   chain_wdata, chain_rd_q;

  logic               accept;
  logic               cache_full;
  logic               out_free;
  logic [PROD_W-1:0]  mod_prod;
  logic               spill_last, refill_last;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = (state_r == ST_IDLE);
  assign cache_full  = (cnt_r == CNT_W'(CACHE_SLOTS));
  assign out_free    = !out_tvalid_r || out_tready;
  assign cache_rd    = rd_zero_r ? '0 : cache_rd_q;
  assign mod_prod    = PROD_W'(rem_r) * PROD_W'(MOD_M);
  assign spill_last  = (idx_r == OFF_W'(CACHE_SLOTS));
  assign refill_last = (idx_r == OFF_W'(CACHE_SLOTS + 1));
  assign chain_addr  = base_r + ADDR_W'(idx_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(16 - BLK_W){1'b0}}, out_block_r};
  assign out_tuser  = out_status_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_tuser[0] == KIND_FREE) begin
            state_nxt = cache_full ? ST_MOD : ST_PUSH;
          end else if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_POP_RD;
          end
        end
      end
      ST_PUSH:   state_nxt = ST_DONE;
      ST_POP_RD: state_nxt = ST_POP_CHK;
      ST_POP_CHK: begin
        if (cache_rd != '0 && cnt_r == CNT_W'(1)) begin
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOD: begin
        if (mod_ph_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:    state_nxt = (kind_r == KIND_FREE) ? ST_SPILL : ST_REFILL;
      ST_SPILL: begin
        if (spill_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_REFILL: begin
        if (refill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    kind_nxt       = kind_r;
    blk_nxt        = blk_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    mod_ph_nxt     = mod_ph_r;
    quo_nxt        = quo_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    got_nxt        = got_r;
    status_nxt     = status_r;
    slot0_vld_nxt  = slot0_vld_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_block_nxt  = out_block_r;
    out_status_nxt = out_status_r;
    cache_we       = 1'b0;
    cache_waddr    = '0;
    cache_wdata    = '0;
    cache_re       = 1'b0;
    cache_raddr    = '0;
    chain_we       = 1'b0;
    chain_re       = 1'b0;
    chain_wdata    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_tuser[0];
          blk_nxt    = in_tdata[BLK_W-1:0];
          rem_nxt    = in_tdata[BLK_W-1:0];
          mod_ph_nxt = 1'b0;
          got_nxt    = '0;
          status_nxt = (in_tuser[0] == KIND_FREE) ? STAT_FREED : STAT_NOSPACE;
        end
      end
      ST_PUSH: begin
        cache_we    = 1'b1;
        cache_waddr = CIDX_W'(cnt_r);
        cache_wdata = blk_r;
        cnt_nxt     = cnt_r + CNT_W'(1);
      end
      ST_POP_RD: begin
        cache_re    = 1'b1;
        cache_raddr = CIDX_W'(cnt_r - CNT_W'(1));
      end
      ST_POP_CHK: begin
        // Popping the sentinel means no space; count drops to zero
        priority if (cache_rd == '0) begin
          cnt_nxt    = '0;
          status_nxt = STAT_NOSPACE;
        end else begin
          cnt_nxt    = cnt_r - CNT_W'(1);
          got_nxt    = cache_rd;
          rem_nxt    = cache_rd;
          mod_ph_nxt = 1'b0;
          status_nxt = STAT_ALLOC;
        end
      end
      ST_MOD: begin
        // Record number: quotient by reciprocal multiply, then subtract
        if (!mod_ph_r) begin
          quo_nxt = BLK_W'(mod_prod >> MOD_SH);
        end else begin
          rem_nxt = rem_r - quo_r * BLK_W'(REC_COUNT);
        end
        mod_ph_nxt = !mod_ph_r;
      end
      ST_MUL: begin
        base_nxt = ADDR_W'(ADDR_W'(rem_r) * ADDR_W'(REC_WORDS));
        idx_nxt  = '0;
      end
      ST_SPILL: begin
        // Read cache slot idx; write the count word first, then the slot read last cycle
        if (!spill_last) begin
          cache_re    = 1'b1;
          cache_raddr = CIDX_W'(idx_r);
        end
        chain_we    = 1'b1;
        chain_wdata = (idx_r == '0) ? BLK_W'(CACHE_SLOTS) : cache_rd;
        idx_nxt     = idx_r + OFF_W'(1);
        if (spill_last) begin
          cnt_nxt = '0;
        end
      end
      ST_REFILL: begin
        if (!refill_last) begin
          chain_re = 1'b1;
        end
        if (idx_r == OFF_W'(1)) begin
          cnt_nxt = (chain_rd_q > BLK_W'(CACHE_SLOTS)) ? CNT_W'(CACHE_SLOTS)
                                                      : CNT_W'(chain_rd_q);
        end else if (idx_r != '0) begin
          cache_we    = 1'b1;
          cache_waddr = CIDX_W'(idx_r - OFF_W'(2));
          cache_wdata = chain_rd_q;
        end
        idx_nxt = idx_r + OFF_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_block_nxt  = got_r;
          out_status_nxt = status_r;
        end
      end
      default: ;
    endcase

    if (cache_we && cache_waddr == '0) begin
      slot0_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= CNT_W'(1);
      slot0_vld_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      slot0_vld_r  <= slot0_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    blk_r        <= blk_nxt;
    rem_r        <= rem_nxt;
    mod_ph_r     <= mod_ph_nxt;
    quo_r        <= quo_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    got_r        <= got_nxt;
    status_r     <= status_nxt;
    out_block_r  <= out_block_nxt;
    out_status_r <= out_status_nxt;
  end

  // Cache memory; slot 0 reads as the sentinel until first written
  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    if (cache_re) begin
      cache_rd_q <= cache_mem[cache_raddr];
      rd_zero_r  <= (cache_raddr == '0) && !slot0_vld_r;
    end
  end

  // Chain record memory, single port
  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_addr] <= chain_wdata;
    end
    if (chain_re) begin
      chain_rd_q <= chain_mem[chain_addr];
    end
  end

endmodule

FILE: tb/chained_free_block_allocator_tb.sv
// Self-checking testbench for the chained free-block allocator: free and allocate
// requests against a free-list predictor, with idle and stall phases.
// Depends on cfba_pkg and chained_free_block_allocator.
`timescale 1ns / 1ps

module chained_free_block_allocator_tb;
  import cfba_pkg::*;

  localparam int CACHE_SLOTS = DEF_CACHE_SLOTS;
  localparam int BLOCK_COUNT = DEF_BLOCK_COUNT;
  localparam int REC_WORDS   = CACHE_SLOTS + 1;
  localparam int RANDOM_PER_PHASE = 388;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  // free-list copies: one tracks the stimulus as it is generated, one predicts results
  localparam int SHADOW = 0;
  localparam int PREDICT = 1;

  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] blk;
  } alloc_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted;
    status_t          status;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [9:0] block_number
  logic [0:0]  in_tuser = '0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [9:0] granted_block
  logic [1:0]  out_tuser;       // [1:0] status

  logic [BLK_W-1:0] free_cache  [2][CACHE_SLOTS];
  int               free_count  [2];
  logic [BLK_W-1:0] chain_mem   [2][BLOCK_COUNT*REC_WORDS];
  bit               rec_written [2][BLOCK_COUNT];

  alloc_req_t    request_q [$];
  alloc_result_t grant_expect_q [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_arm = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;

  chained_free_block_allocator #(
    .CACHE_SLOTS(CACHE_SLOTS),
    .BLOCK_COUNT(BLOCK_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_free_list(input int unit);
    for (int i = 0; i < CACHE_SLOTS; i++) free_cache[unit][i] = '0;
    for (int b = 0; b < BLOCK_COUNT; b++) rec_written[unit][b] = 1'b0;
    free_count[unit] = 1;
  endfunction

  // Apply one request to a free-list copy and return its result.
  function automatic alloc_result_t free_list_step(input int unit, input logic kind,
                                                   input logic [BLK_W-1:0] blk);
    alloc_result_t res;
    logic [BLK_W-1:0] got;
    int base;
    int n;
    res.granted = '0;
    if (kind == KIND_FREE) begin
      if (free_count[unit] >= CACHE_SLOTS) begin
        // spill the full cache into the freed block's chain record
        base = (int'(blk) % BLOCK_COUNT) * REC_WORDS;
        chain_mem[unit][base] = BLK_W'(CACHE_SLOTS);
        for (int i = 0; i < CACHE_SLOTS; i++) chain_mem[unit][base+1+i] = free_cache[unit][i];
        rec_written[unit][int'(blk) % BLOCK_COUNT] = 1'b1;
        free_count[unit] = 0;
      end
      free_cache[unit][free_count[unit]] = blk;
      free_count[unit]++;
      res.status = STAT_FREED;
    end else if (free_count[unit] == 0) begin
      res.status = STAT_NOSPACE;
    end else begin
      free_count[unit]--;
      got = free_cache[unit][free_count[unit]];
      if (got == '0) begin
        free_count[unit] = 0;
        res.status = STAT_NOSPACE;
      end else begin
        if (free_count[unit] == 0) begin
          // cache ran dry: reload it from the popped block's chain record
          base = (int'(got) % BLOCK_COUNT) * REC_WORDS;
          n = int'(chain_mem[unit][base]);
          if (n > CACHE_SLOTS) n = CACHE_SLOTS;
          free_count[unit] = n;
          for (int i = 0; i < CACHE_SLOTS; i++) free_cache[unit][i] = chain_mem[unit][base+1+i];
        end
        res.granted = got;
        res.status = STAT_ALLOC;
      end
    end
    return res;
  endfunction

  // An allocation that pops the last cached block reads that block's record.
  function automatic bit refill_unwritten();
    return free_count[SHADOW] == 1 && free_cache[SHADOW][0] != '0 &&
           !rec_written[SHADOW][int'(free_cache[SHADOW][0]) % BLOCK_COUNT];
  endfunction

  task automatic queue_request(input logic kind, input logic [BLK_W-1:0] blk);
    alloc_req_t req;
    alloc_result_t unused;
    // turn an allocation that would reload a never-written record into a free
    if (kind == KIND_ALLOC && refill_unwritten()) begin
      kind = KIND_FREE;
      blk = BLK_W'($urandom_range(BLOCK_COUNT - 1));
    end
    unused = free_list_step(SHADOW, kind, blk);
    req.kind = kind;
    req.blk = blk;
    request_q.push_back(req);
  endtask

  task automatic queue_random(input int count);
    int done;
    int burst;
    int alloc_pct;
    int r;
    logic kind;
    logic [BLK_W-1:0] blk;
    done = 0;
    while (done < count) begin
      // bursts of mostly frees or mostly allocations drive spills and refills
      burst = $urandom_range(40, 1);
      r = $urandom_range(9);
      alloc_pct = (r < 4) ? 85 : (r < 8) ? 15 : 50;
      for (int i = 0; i < burst && done < count; i++) begin
        kind = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
        r = $urandom_range(99);
        blk = (r < 4) ? '0 : (r < 7) ? BLK_W'(BLOCK_COUNT - 1) : BLK_W'($urandom_range(1023));
        queue_request(kind, blk);
        done++;
      end
    end
  endtask

  task automatic queue_directed();
    logic [BLK_W-1:0] fill [16];
    fill = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd2, 10'd4, 10'd8,
             10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd3, 10'd0, 10'h3F0};
    queue_request(KIND_ALLOC, 10'd0);    // pop the sentinel left by reset
    queue_request(KIND_ALLOC, 10'd1023); // empty cache
    for (int i = 0; i < 16; i++) queue_request(KIND_FREE, fill[i]);
    queue_request(KIND_FREE, 10'd512);   // full cache spills into block 512
    queue_request(KIND_ALLOC, 10'd0);    // pop 512 and reload its record
    queue_request(KIND_ALLOC, 10'd0);
    queue_request(KIND_ALLOC, 10'd0);    // sentinel in mid cache
    queue_request(KIND_ALLOC, 10'd0);
  endtask

  // driver
  always @(posedge clk) begin
    alloc_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        grant_expect_q.push_back(free_list_step(PREDICT, in_tuser[0], in_tdata[BLK_W-1:0]));
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, req.blk};
          in_tuser <= req.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_result_t exp;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (grant_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got block %0d status %0d",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          exp = grant_expect_q.pop_front();
          if (out_tdata !== {6'd0, exp.granted}) begin
            $display("%0t: granted_block mismatch, expected %0d, got %0d",
                     $time, exp.granted, out_tdata);
            mismatches++;
          end
          if (out_tuser !== exp.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp.status, out_tuser);
            mismatches++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 46, 0, 32};
    recv_pct = '{0, 0, 46, 32};
    reset_free_list(SHADOW);
    reset_free_list(PREDICT);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      send_idle_pct = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      if (phase == 0) queue_directed();
      queue_random(RANDOM_PER_PHASE);
      if (phase == 1) begin
        // long receiver hold-off while requests keep coming
        hold_arm = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
      end
      // wait until every request is sent and every result is back
      while (request_q.size() > 0 || in_tvalid || grant_expect_q.size() > 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
    if (mismatches == 0 && grant_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, grant_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
